// ===== sv/c3cf_pkg.sv =====
// Shared types and constants for the 3x3 convolution filter.
`timescale 1ns / 1ps

package c3cf_pkg;

	// Field widths
	localparam int PIX_W     = 8;
	localparam int IMG_W_W   = 11;
	localparam int IMG_H_W   = 13;
	localparam int COEF_W    = 16;
	localparam int KROW_W    = 3 * COEF_W;
	localparam int CFG_IDX_W = 3;

	// Line position: one spare bit over the height, flushing runs past the last line
	localparam int ROW_W = IMG_H_W + 1;
	// Results per frame: up to width times height
	localparam int CNT_W = IMG_W_W + IMG_H_W;

	// Multiply-accumulate widths: unsigned pixel times signed coefficient, nine terms
	localparam int PROD_W = PIX_W + 1 + COEF_W;
	localparam int SUM_W  = PROD_W + 4;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

	// Register reset values
	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST   = 11'd640;
	localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST  = 13'd480;
	localparam logic [KROW_W-1:0]  KERNEL_OUTER_RST  = 48'h0000_0000_0000;
	localparam logic [KROW_W-1:0]  KERNEL_MIDDLE_RST = 48'h0000_0100_0000;

	typedef logic [PIX_W-1:0] pix_t;
	// Window taps, index row*3 + column, column 0 on the left
	typedef logic [8:0][PIX_W-1:0] win_t;
	// Kernel rows: top, middle, bottom
	typedef logic [2:0][KROW_W-1:0] kern_t;

	// Per-beat control that travels alongside the window
	typedef struct packed {
		logic emit;
		logic eof;
		logic border;
	} ctl_t;

endpackage

// ===== sv/c3cf_kernel.sv =====
// Nine-tap multiply stage, adder and clamp, with the result register.
`timescale 1ns / 1ps

module c3cf_kernel #(
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  c3cf_pkg::ctl_t    ctl_in,
	input  c3cf_pkg::win_t    win,
	input  c3cf_pkg::kern_t   kern,
	output logic              out_valid,
	output c3cf_pkg::pix_t    pixel_out,
	output logic              end_of_frame
);
	import c3cf_pkg::*;

	logic signed [COEF_W-1:0] coef [9];
	logic signed [PROD_W-1:0] prod_s3 [9];
	ctl_t                     ctl_s3;
	pix_t                     centre_s3;
	logic signed [SUM_W-1:0]  sum;
	pix_t                     filt;
	logic                     valid_q;
	logic                     eof_q;
	pix_t                     pix_q;

	// Unpack the coefficients per tap
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coef[r * 3 + c] = kern[r][c * COEF_W +: COEF_W];
			end
		end
	end

	// Stage 3: products, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			centre_s3 <= win[4];
			for (int i = 0; i < 9; i++) begin
				prod_s3[i] <= PROD_W'($signed({1'b0, win[i]}) * coef[i]);
			end
		end
	end

	// Sum of the nine products, truncate and clamp to 0..255
	always_comb begin
		sum = '0;
		for (int i = 0; i < 9; i++) begin
			sum = sum + SUM_W'(prod_s3[i]);
		end
		if (sum[SUM_W-1] || sum == '0) begin
			filt = '0;
		end else if (|sum[SUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
			filt = PIX_MAX;
		end else begin
			filt = sum[COEF_FRAC_BITS +: PIX_W];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			eof_q   <= 1'b0;
		end else if (adv) begin
			valid_q <= ctl_s3.emit;
			eof_q   <= ctl_s3.emit && ctl_s3.eof;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_q <= ctl_s3.border ? centre_s3 : filt;
		end
	end

	assign out_valid    = valid_q;
	assign pixel_out    = pix_q;
	assign end_of_frame = eof_q;

endmodule

// ===== sv/conv3x3_clamp_filter.sv =====
// Top level: 3x3 convolution over a raster pixel stream with two line stores.
// Pipeline: the beat that completes a pixel's window (input beat k+W+1 for pixel k,
//   W = image width) passes stage 1, window, products and the result register.
// Throughput: a pixel per cycle unless output stalls; line store: 1 read, 1 write.
// Reset: clears counters, window, pipeline valids and loads the register defaults;
//   line stores are not cleared and hold nothing meaningful until written.
`timescale 1ns / 1ps

module conv3x3_clamp_filter #(
	parameter int MAX_WIDTH      = 1024,
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  c3cf_pkg::pix_t                  pixel_in,
	input  logic                            is_fill,
	output logic                            out_valid,
	input  logic                            out_ready,
	output c3cf_pkg::pix_t                  pixel_out,
	output logic                            end_of_frame,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [c3cf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [c3cf_pkg::KROW_W-1:0]     cfg_data
);
	import c3cf_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CMP_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

	// Configuration registers
	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	kern_t              kern_q;

	// Position of the next beat and results given in this frame
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] cnt_q;

	// Line store: [15:8] upper line, [7:0] lower line
	logic [2*PIX_W-1:0] mem [MAX_WIDTH];

	logic               upd_s1;
	ctl_t               ctl_s1;
	pix_t               p_s1;
	logic [COL_W-1:0]   col_s1;
	logic [2*PIX_W-1:0] rd_s1;

	win_t win_q;
	ctl_t ctl_s2;

	logic               adv;
	logic               acc;
	logic               go;
	logic [IMG_W_W-1:0] eff_w;
	logic [IMG_H_W-1:0] eff_h;
	logic [CNT_W-1:0]   total;
	logic               in_frame;
	logic               wrap;
	logic               emit;
	logic               eof;
	logic               border;
	pix_t               p_in;
	logic               mem_we;
	logic [2*PIX_W-1:0] mem_wdata;

	// Handshake: everything moves unless a result is held
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign acc       = in_valid && adv;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= IMAGE_WIDTH_RST;
			height_q  <= IMAGE_HEIGHT_RST;
			kern_q[0] <= KERNEL_OUTER_RST;
			kern_q[1] <= KERNEL_MIDDLE_RST;
			kern_q[2] <= KERNEL_OUTER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   width_q   <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT:  height_q  <= cfg_data[IMG_H_W-1:0];
				REG_KERNEL_TOP:    kern_q[0] <= cfg_data;
				REG_KERNEL_MIDDLE: kern_q[1] <= cfg_data;
				REG_KERNEL_BOTTOM: kern_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective geometry
	always_comb begin
		if (width_q == '0) begin
			eff_w = IMG_W_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = IMG_W_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q == '0) ? IMG_H_W'(1) : height_q;
		total = CNT_W'(eff_w) * CNT_W'(eff_h);
	end

	// Beat decode: drop, tail flush, emit, border, frame end
	always_comb begin
		in_frame = row_q < ROW_W'(eff_h);
		go       = acc && !(is_fill && in_frame);
		p_in     = in_frame ? pixel_in : '0;
		wrap     = CMP_W'(col_q) + CMP_W'(1) >= CMP_W'(eff_w);
		emit     = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
		eof      = emit && ((CNT_W+1)'(cnt_q) + (CNT_W+1)'(1) >= (CNT_W+1)'(total));
		border   = (col_q == '0) || (col_q == COL_W'(1))
			|| (CMP_W'(col_q) >= CMP_W'(eff_w))
			|| (row_q == ROW_W'(1)) || (row_q >= ROW_W'(eff_h));
	end

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
		end else if (go) begin
			if (eof) begin
				col_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
			end else begin
				if (wrap) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
				if (emit) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= 1'b0;
			ctl_s1 <= '0;
		end else if (adv) begin
			upd_s1 <= go;
			ctl_s1 <= '{emit: go && emit, eof: eof, border: border};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1   <= p_in;
			col_s1 <= col_q;
		end
	end

	// Line store: write back as stage 1 leaves, read for the incoming beat.
	// With a one-pixel line both hit the same entry, so the write data is forwarded.
	assign mem_we    = upd_s1 && adv;
	assign mem_wdata = {rd_s1[PIX_W-1:0], p_s1};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[col_s1] <= mem_wdata;
		end
		if (adv) begin
			if (mem_we && col_s1 == col_q) begin
				rd_s1 <= mem_wdata;
			end else begin
				rd_s1 <= mem[col_q];
			end
		end
	end

	// Stage 2: window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			if (upd_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r * 3]     <= win_q[r * 3 + 1];
					win_q[r * 3 + 1] <= win_q[r * 3 + 2];
				end
				win_q[2] <= rd_s1[2*PIX_W-1:PIX_W];
				win_q[5] <= rd_s1[PIX_W-1:0];
				win_q[8] <= p_s1;
			end
		end
	end

	// Stages 3 and result
	c3cf_kernel #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_kernel (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctl_in      (ctl_s2),
		.win         (win_q),
		.kern        (kern_q),
		.out_valid   (out_valid),
		.pixel_out   (pixel_out),
		.end_of_frame(end_of_frame)
	);

endmodule

// ===== sv/c3cf_checker.sv =====
// Port-level checks for the 3x3 convolution filter, bound to the top level.
`timescale 1ns / 1ps

module c3cf_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input c3cf_pkg::pix_t        pixel_out,
	input logic                  end_of_frame
);
	import c3cf_pkg::*;

	// A held result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn before acceptance");

	// A held result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_out) && $stable(end_of_frame))
		else $error("result payload changed while stalled");

	// A stalled output stops the input side
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while the result is stalled");

	// With no result pending the input is always open
	a_open_in: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with an empty output register");

endmodule

bind conv3x3_clamp_filter c3cf_checker u_c3cf_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the 3x3 convolution filter with clamped 8-bit output.
`timescale 1ns / 1ps

module testbench;
	import c3cf_pkg::*;

	localparam int MAX_W          = 1024;
	localparam int FRAC_BITS      = 8;
	localparam int IDLE_GAP       = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int RANDOM_BEATS   = 1300;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_FULL, PIX_ZERO, PIX_RAMP} pix_style_t;
	typedef enum {KERN_ANY, KERN_SMALL, KERN_EDGE, KERN_BLUR} kern_style_t;
	typedef enum {RX_OPEN, RX_COIN, RX_CADENCE, RX_SPARSE} rx_mode_t;

	typedef struct {
		pix_t pixel;
		logic eof;
	} frame_result_t;

	// Raster-order convolution predictor with its own line stores and window
	class conv_scoreboard;
		logic [IMG_W_W-1:0] width_reg;
		logic [IMG_H_W-1:0] height_reg;
		kern_t              kern;
		pix_t               upper_line [MAX_W];
		pix_t               lower_line [MAX_W];
		pix_t               win [9];
		int unsigned        col, row, done_count;
		frame_result_t      pending_pixels [$];
		int unsigned        beats_taken, fills_dropped, results_seen, frames_ended;
		int unsigned        reg_writes, mismatches;

		function new();
			width_reg  = IMAGE_WIDTH_RST;
			height_reg = IMAGE_HEIGHT_RST;
			kern[0]    = KERNEL_OUTER_RST;
			kern[1]    = KERNEL_MIDDLE_RST;
			kern[2]    = KERNEL_OUTER_RST;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col = 0;
			row = 0;
			done_count = 0;
		endfunction

		function int unsigned eff_w();
			int unsigned v = width_reg;
			if (v == 0) v = 1;
			if (v > MAX_W) v = MAX_W;
			return v;
		endfunction

		function int unsigned eff_h();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_IMAGE_WIDTH:   width_reg  = data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT:  height_reg = data[IMG_H_W-1:0];
				REG_KERNEL_TOP:    kern[0]    = data;
				REG_KERNEL_MIDDLE: kern[1]    = data;
				REG_KERNEL_BOTTOM: kern[2]    = data;
				default: ;
			endcase
		endfunction

		// Weighted sum of the window, truncated and clamped to a pixel
		function pix_t clamped_sum();
			longint acc = 0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					acc += longint'(win[r*3+c])
						* longint'($signed(kern[r][c*COEF_W +: COEF_W]));
			if (acc <= 0) return '0;
			acc = acc >>> FRAC_BITS;
			if (acc > 255) return PIX_MAX;
			return pix_t'(acc);
		endfunction

		// One accepted input beat: advance the window, maybe queue a result
		function void note_beat(pix_t pix_in, logic fill);
			int unsigned w, h, total, c0, r0, cr, cc;
			bit          in_frame, emit, eof;
			pix_t        p, top, mid, val;
			w = eff_w();
			h = eff_h();
			total = w * h;
			in_frame = row < h;
			if (fill && in_frame) begin
				fills_dropped++;
				return;
			end
			beats_taken++;
			p = in_frame ? pix_in : '0;
			c0 = col;
			r0 = row;
			top = upper_line[c0];
			mid = lower_line[c0];
			upper_line[c0] = mid;
			lower_line[c0] = p;
			for (int r = 0; r < 3; r++) begin
				win[r*3]   = win[r*3+1];
				win[r*3+1] = win[r*3+2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = p;

			emit = r0 >= 2 || (r0 == 1 && c0 >= 1);
			cr = 0;
			cc = 0;
			if (emit) begin
				if (c0 == 0) begin
					cr = r0 - 2;
					cc = w - 1;
				end else begin
					cr = r0 - 1;
					cc = c0 - 1;
				end
			end
			if (c0 + 1 >= w) begin
				col = 0;
				row = r0 + 1;
			end else begin
				col = c0 + 1;
			end
			if (!emit) return;

			// Border pixels pass straight through
			if (cr == 0 || cr + 1 >= h || cc == 0 || cc + 1 >= w)
				val = win[4];
			else
				val = clamped_sum();
			eof = done_count + 1 >= total;
			if (eof) begin
				col = 0;
				row = 0;
				done_count = 0;
			end else begin
				done_count++;
			end
			pending_pixels.push_back('{val, eof});
		endfunction

		function void check_result(pix_t got_pix, logic got_eof);
			frame_result_t exp_res;
			results_seen++;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: pixel %0d eof %0b",
						$time, got_pix, got_eof);
				return;
			end
			exp_res = pending_pixels.pop_front();
			if (got_pix !== exp_res.pixel || got_eof !== exp_res.eof) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result %0d: expected pixel %0d eof %0b, %s %0d eof %0b",
						$time, results_seen, exp_res.pixel, exp_res.eof, "got pixel",
						got_pix, got_eof);
			end else if (got_eof) begin
				frames_ended++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	pix_t                 pixel_in  = '0;
	logic                 is_fill   = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	pix_t                 pixel_out;
	logic                 end_of_frame;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KROW_W-1:0]    cfg_data  = '0;

	conv_scoreboard sb;
	int unsigned    quiet_cycles = 0;
	int unsigned    burst_left   = 0;

	conv3x3_clamp_filter #(
		.MAX_WIDTH(MAX_W),
		.COEF_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_in(pixel_in),
		.is_fill(is_fill),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_out(pixel_out),
		.end_of_frame(end_of_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Beat monitor: feeds the predictor and checks results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
			if (in_valid && in_ready) sb.note_beat(pixel_in, is_fill);
			if (out_valid && out_ready) sb.check_result(pixel_out, end_of_frame);
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver back-pressure: the mode is picked anew at random once its random hold runs out
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_tick = 0;

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(3));
			rx_left <= $urandom_range(50, 400);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:    out_ready <= 1'b1;
			RX_COIN:    out_ready <= ($urandom_range(3) != 0);
			RX_CADENCE: out_ready <= (rx_tick % 5) < 3;
			default:    out_ready <= (rx_tick % 7) == 0;
		endcase
	end

	// Watchdog on cycles without any beat
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("[%0t] no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("** conv3x3_clamp_filter: FAILED **");
		$finish;
	end

	// Sender pacing: bursts of random length, random gaps between them
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
	endtask

	task automatic send_beat(pix_t p, logic fill);
		pace_sender();
		in_valid <= 1'b1;
		pixel_in <= p;
		is_fill  <= fill;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold the sender until every queued result has come back
	task automatic drain(int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_pixels.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] data);
		drain(IDLE_GAP);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Geometry writes carry random junk above the register width
	task automatic set_geometry(int unsigned w, int unsigned h);
		logic [KROW_W-1:0] d;
		d = KROW_W'({$urandom(), $urandom()});
		d[IMG_W_W-1:0] = IMG_W_W'(w);
		write_reg(REG_IMAGE_WIDTH, d);
		d = KROW_W'({$urandom(), $urandom()});
		d[IMG_H_W-1:0] = IMG_H_W'(h);
		write_reg(REG_IMAGE_HEIGHT, d);
	endtask

	task automatic set_kernel(logic [KROW_W-1:0] top, logic [KROW_W-1:0] mid,
			logic [KROW_W-1:0] bot);
		write_reg(REG_KERNEL_TOP, top);
		write_reg(REG_KERNEL_MIDDLE, mid);
		write_reg(REG_KERNEL_BOTTOM, bot);
	endtask

	function automatic logic [KROW_W-1:0] pack_row(logic [COEF_W-1:0] l, logic [COEF_W-1:0] c,
			logic [COEF_W-1:0] r);
		return {r, c, l};
	endfunction

	function automatic logic [KROW_W-1:0] random_kernel_row(kern_style_t s);
		logic [COEF_W-1:0] co [3];
		for (int i = 0; i < 3; i++) begin
			case (s)
				KERN_ANY:   co[i] = COEF_W'($urandom());
				KERN_SMALL: co[i] = COEF_W'($urandom_range(192)) - COEF_W'(96);
				KERN_BLUR:  co[i] = COEF_W'(24 + $urandom_range(8));
				default: begin
					case ($urandom_range(5))
						0:       co[i] = 16'h7FFF;
						1:       co[i] = 16'h8000;
						2:       co[i] = 16'hFFFF;
						3:       co[i] = 16'h0001;
						4:       co[i] = 16'h0000;
						default: co[i] = 16'h0100;
					endcase
				end
			endcase
		end
		return pack_row(co[0], co[1], co[2]);
	endfunction

	function automatic pix_t frame_pixel(pix_style_t s, int unsigned k, int unsigned w);
		case (s)
			PIX_RANDOM:  return pix_t'($urandom());
			PIX_EXTREME: return $urandom_range(1) ? PIX_MAX : pix_t'(0);
			PIX_FULL:    return PIX_MAX;
			PIX_ZERO:    return '0;
			default:     return pix_t'(k * 37 + (k / w) * 11);
		endcase
	endfunction

	// One frame of pixels with dropped fill noise, then the flushing tail
	task automatic run_frame(pix_style_t s, int unsigned noise_pct, int unsigned hold_odds);
		int unsigned w, h;
		w = sb.eff_w();
		h = sb.eff_h();
		for (int unsigned k = 0; k < w * h; k++) begin
			if ($urandom_range(99) < noise_pct) send_beat(pix_t'($urandom()), 1'b1);
			send_beat(frame_pixel(s, k, w), 1'b0);
			if (hold_odds != 0 && $urandom_range(hold_odds - 1) == 0) drain(0);
		end
		for (int unsigned k = 0; k <= w; k++)
			send_beat(pix_t'($urandom()), 1'($urandom_range(1)));
	endtask

	task automatic directed_frames();
		// Reset kernel is the identity: only geometry written
		set_geometry(5, 4);
		run_frame(PIX_RANDOM, 0, 0);
		run_frame(PIX_EXTREME, 20, 0);
		// Zero geometry behaves as a single pixel
		set_geometry(0, 0);
		run_frame(PIX_FULL, 0, 0);
		run_frame(PIX_RANDOM, 50, 0);
		// Frames too narrow or too short to have an interior
		set_geometry(2, 5);
		run_frame(PIX_RAMP, 10, 0);
		set_geometry(6, 2);
		run_frame(PIX_RANDOM, 10, 0);
		set_geometry(3, 1);
		run_frame(PIX_EXTREME, 0, 0);
		// Largest positive coefficients saturate
		set_geometry(3, 3);
		set_kernel(pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF), pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
			pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
		run_frame(PIX_FULL, 0, 0);
		run_frame(PIX_ZERO, 0, 0);
		run_frame(PIX_RANDOM, 0, 0);
		// Most negative coefficients floor at zero
		set_geometry(4, 4);
		set_kernel(pack_row(16'h8000, 16'h8000, 16'h8000), pack_row(16'h8000, 16'h8000, 16'h8000),
			pack_row(16'h8000, 16'h8000, 16'h8000));
		run_frame(PIX_FULL, 0, 0);
		// Mixed signs and single-LSB coefficients exercise truncation
		set_geometry(5, 5);
		set_kernel(pack_row(16'hFFFF, 16'h0001, 16'h7FFF), pack_row(16'h8000, 16'h0100, 16'hFFFF),
			pack_row(16'h0001, 16'h0000, 16'h8000));
		run_frame(PIX_RANDOM, 5, 0);
		run_frame(PIX_EXTREME, 5, 0);
		// Longer lines with small random outer rows and a blurring middle row
		set_geometry(24, 3);
		set_kernel(random_kernel_row(KERN_SMALL), random_kernel_row(KERN_BLUR),
			random_kernel_row(KERN_SMALL));
		run_frame(PIX_RANDOM, 2, 0);
	endtask

	function automatic int unsigned random_width();
		int unsigned r = $urandom_range(99);
		if (r < 5) return 0;
		if (r < 75) return $urandom_range(1, 8);
		if (r < 95) return $urandom_range(9, 24);
		return $urandom_range(25, 64);
	endfunction

	function automatic int unsigned random_height();
		int unsigned r = $urandom_range(99);
		if (r < 5) return 0;
		if (r < 80) return $urandom_range(1, 8);
		return $urandom_range(9, 20);
	endfunction

	task automatic random_frames();
		int unsigned start;
		bit          first;
		pix_style_t  st;
		start = sb.beats_taken;
		first = 1'b1;
		while (sb.beats_taken - start < RANDOM_BEATS) begin
			if (first || $urandom_range(1)) set_geometry(random_width(), random_height());
			if (first || $urandom_range(1))
				write_reg(REG_KERNEL_TOP, random_kernel_row(kern_style_t'($urandom_range(3))));
			if (first || $urandom_range(1))
				write_reg(REG_KERNEL_MIDDLE, random_kernel_row(kern_style_t'($urandom_range(3))));
			if (first || $urandom_range(1))
				write_reg(REG_KERNEL_BOTTOM, random_kernel_row(kern_style_t'($urandom_range(3))));
			// Writes to unmapped indexes must change nothing
			if ($urandom_range(9) == 0)
				write_reg(CFG_IDX_W'(REG_KERNEL_BOTTOM + 1 + $urandom_range(2)),
					KROW_W'({$urandom(), $urandom()}));
			first = 1'b0;
			repeat ($urandom_range(1, 3)) begin
				st = ($urandom_range(3) != 0) ? PIX_RANDOM : pix_style_t'($urandom_range(4));
				run_frame(st, $urandom_range(15), 300);
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_frames();
		random_frames();
		drain(TAIL_CYCLES);
		$display("Covered %0d beats (%0d fill beats dropped mid-frame) over %0d frames,",
			sb.beats_taken, sb.fills_dropped, sb.frames_ended);
		$display("%0d register writes; checked %0d results: %0d mismatches, %0d outstanding.",
			sb.reg_writes, sb.results_seen, sb.mismatches, sb.pending_pixels.size());
		if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
			$display("** conv3x3_clamp_filter: PASSED **");
		end else begin
			$display("** conv3x3_clamp_filter: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/c3cf_pkg.sv
sv/c3cf_kernel.sv
sv/conv3x3_clamp_filter.sv
sv/c3cf_checker.sv
tb/testbench.sv
